// File: src/spq_pkg.sv
package spq_pkg;

  // default queue depth
  localparam int unsigned CAPACITY_DEFAULT = 16;

  // one stored event
  typedef struct packed {
    logic [7:0]         prio;
    logic [7:0]         system_id;
    logic [7:0]         resource_id;
    logic [3:0]         status_code;
    logic signed [31:0] amount;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // request action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // jump conditions tested by a control word
  typedef enum logic [2:0] {
    C_ACCEPT   = 3'd0,
    C_IS_POP   = 3'd1,
    C_FULL     = 3'd2,
    C_WALK_END = 3'd3,
    C_PRIO_GE  = 3'd4,
    C_EMPTY    = 3'd5,
    C_OUT_FREE = 3'd6,
    C_ALWAYS   = 3'd7
  } cond_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LATCH  = 4'd1,
    OP_SETUP  = 4'd2,
    OP_FULL   = 4'd3,
    OP_READ   = 4'd4,
    OP_SHIFT  = 4'd5,
    OP_INSERT = 4'd6,
    OP_EMPTY  = 4'd7,
    OP_POPRD  = 4'd8,
    OP_TAKE   = 4'd9,
    OP_EMIT   = 4'd10
  } op_t;

  localparam int unsigned STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE     = 3'd0;
  localparam step_t STEP_DISPATCH = 3'd1;
  localparam step_t STEP_CHK_FULL = 3'd2;
  localparam step_t STEP_WALK     = 3'd3;
  localparam step_t STEP_CMP      = 3'd4;
  localparam step_t STEP_POP_CHK  = 3'd5;
  localparam step_t STEP_TAKE     = 3'd6;
  localparam step_t STEP_DONE     = 3'd7;

  // control word: operation and next step for condition true and false
  typedef struct packed {
    cond_t cond;
    op_t   op_hit;
    step_t next_hit;
    op_t   op_miss;
    step_t next_miss;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    unique case (step)
      STEP_IDLE:     w = '{C_ACCEPT,   OP_LATCH,  STEP_DISPATCH, OP_NONE,  STEP_IDLE};
      STEP_DISPATCH: w = '{C_IS_POP,   OP_NONE,   STEP_POP_CHK,  OP_NONE,  STEP_CHK_FULL};
      STEP_CHK_FULL: w = '{C_FULL,     OP_FULL,   STEP_DONE,     OP_SETUP, STEP_WALK};
      STEP_WALK:     w = '{C_WALK_END, OP_INSERT, STEP_DONE,     OP_READ,  STEP_CMP};
      STEP_CMP:      w = '{C_PRIO_GE,  OP_INSERT, STEP_DONE,     OP_SHIFT, STEP_WALK};
      STEP_POP_CHK:  w = '{C_EMPTY,    OP_EMPTY,  STEP_DONE,     OP_POPRD, STEP_TAKE};
      STEP_TAKE:     w = '{C_ALWAYS,   OP_TAKE,   STEP_DONE,     OP_TAKE,  STEP_DONE};
      STEP_DONE:     w = '{C_OUT_FREE, OP_EMIT,   STEP_IDLE,     OP_NONE,  STEP_DONE};
    endcase
    return w;
  endfunction

endpackage

// File: src/spq_ram.sv
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/stable_priority_event_queue.sv
// channel   direction  handshake            payload
// request   in         req_valid/req_stall  action, priority_req, system_id, resource_id,
//                                           status_code, amount
// response  out        rsp_valid/rsp_stall  result_status, out_priority, out_system_id,
//                                           out_resource_id, out_status_code, out_amount,
//                                           entries_held
//
// one transaction at a time; req_stall is high from acceptance until the result is loaded
// pop: dispatch, empty check, head read and take, then the result is loaded; push to a full
//   queue: dispatch, full check, then the result is loaded
// push: each held entry of lower priority (at most CAPACITY - 1) is read and then written one
//   slot back on the RAM's separate read and write ports; the new entry goes into the hole once
//   an entry of equal or higher priority is met or the walk reaches the front of the queue
// rst (synchronous) empties the queue; the entry RAM itself is never cleared
// a result held under rsp_stall does not block the next request, only the next result
module stable_priority_event_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               action,
  input  logic [7:0]         priority_req,
  input  logic [7:0]         system_id,
  input  logic [7:0]         resource_id,
  input  logic [3:0]         status_code,
  input  logic signed [31:0] amount,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         result_status,
  output logic [7:0]         out_priority,
  output logic [7:0]         out_system_id,
  output logic [7:0]         out_resource_id,
  output logic [3:0]         out_status_code,
  output logic signed [31:0] out_amount,
  output logic [4:0]         entries_held
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
  localparam logic [AW:0]   CAP_WIDE   = (AW + 1)'(CAPACITY);

  // sequencer state
  step_t pc;
  step_t pc_next;
  ucode_t uword;
  logic   hit;
  op_t    op_sel;

  // queue bookkeeping: entries live in a ring starting at head, sorted front to back
  logic [CW-1:0] count;
  logic [AW-1:0] head;

  // insertion walk: rd_ptr is the entry under test, wr_ptr the hole behind it
  logic [CW-1:0] remaining;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;

  // latched request and staged result
  logic    req_action;
  entry_t  new_entry;
  entry_t  res_entry;
  status_t res_status;

  // ram port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  // ring arithmetic
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail_slot;
  logic [AW-1:0] last_used;
  logic [AW-1:0] rd_dec;
  logic [AW-1:0] head_inc;
  logic [31:0]   count_wide;

  logic accept;
  logic out_free;

  assign req_stall = (pc != STEP_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // control word fetch and branch
  assign uword = ucode_rom(pc);

  always_comb begin
    unique case (uword.cond)
      C_ACCEPT:   hit = accept;
      C_IS_POP:   hit = (req_action == ACT_POP);
      C_FULL:     hit = (count == FULL_COUNT);
      C_WALK_END: hit = (remaining == '0);
      C_PRIO_GE:  hit = (ram_rdata.prio >= new_entry.prio);
      C_EMPTY:    hit = (count == '0);
      C_OUT_FREE: hit = out_free;
      C_ALWAYS:   hit = 1'b1;
    endcase
  end

  assign op_sel  = hit ? uword.op_hit   : uword.op_miss;
  assign pc_next = hit ? uword.next_hit : uword.next_miss;

  // slot one past the back of the ring, and the last occupied slot
  always_comb begin
    tail_sum = (AW + 1)'(head) + (AW + 1)'(count);
    if (tail_sum >= CAP_WIDE) begin
      tail_sum = tail_sum - CAP_WIDE;
    end
    tail_slot = tail_sum[AW-1:0];
  end

  assign last_used  = (tail_slot == '0) ? LAST_SLOT : tail_slot - 1'b1;
  assign rd_dec     = (rd_ptr == '0) ? LAST_SLOT : rd_ptr - 1'b1;
  assign head_inc   = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign count_wide = 32'(count);

  // entry store: shifting writes the tested entry one slot back, insert drops the new one in
  assign ram_we    = (op_sel == OP_SHIFT) || (op_sel == OP_INSERT);
  assign ram_waddr = wr_ptr;
  assign ram_wdata = (op_sel == OP_SHIFT) ? ram_rdata : new_entry;
  assign ram_raddr = (op_sel == OP_POPRD) ? head : rd_ptr;

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= STEP_IDLE;
      count     <= '0;
      head      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (op_sel == OP_INSERT) begin
        count <= count + 1'b1;
      end else if (op_sel == OP_TAKE) begin
        count <= count - 1'b1;
        head  <= head_inc;
      end
      if (op_sel == OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (op_sel)
      OP_LATCH: begin
        req_action            <= action;
        new_entry.prio        <= priority_req;
        new_entry.system_id   <= system_id;
        new_entry.resource_id <= resource_id;
        new_entry.status_code <= status_code;
        new_entry.amount      <= amount;
      end
      OP_SETUP: begin
        rd_ptr     <= last_used;
        wr_ptr     <= tail_slot;
        remaining  <= count;
        res_entry  <= '0;
        res_status <= ST_OK;
      end
      OP_FULL: begin
        res_entry  <= '0;
        res_status <= ST_FULL;
      end
      OP_SHIFT: begin
        wr_ptr    <= rd_ptr;
        rd_ptr    <= rd_dec;
        remaining <= remaining - 1'b1;
      end
      OP_EMPTY: begin
        res_entry  <= '0;
        res_status <= ST_EMPTY;
      end
      OP_TAKE: begin
        res_entry  <= ram_rdata;
        res_status <= ST_OK;
      end
      OP_EMIT: begin
        result_status   <= res_status;
        out_priority    <= res_entry.prio;
        out_system_id   <= res_entry.system_id;
        out_resource_id <= res_entry.resource_id;
        out_status_code <= res_entry.status_code;
        out_amount      <= res_entry.amount;
        entries_held    <= count_wide[4:0];
      end
      OP_NONE, OP_READ, OP_INSERT, OP_POPRD: begin
      end
      default: begin
      end
    endcase
  end

  // the held count never passes the capacity
  assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("entry count above capacity");

  // an insert is only ever issued with a free slot
  assert property (@(posedge clk) disable iff (rst) (op_sel == OP_INSERT) |-> (count < FULL_COUNT))
    else $error("insert into a full queue");

  // the walk never examines more entries than are held
  assert property (@(posedge clk) disable iff (rst)
      (pc == STEP_WALK || pc == STEP_CMP) |-> (remaining <= count))
    else $error("insertion walk beyond held entries");

  // the count changes only with an insert or a pop
  assert property (@(posedge clk) disable iff (rst)
      (op_sel != OP_INSERT && op_sel != OP_TAKE) |=> $stable(count))
    else $error("count changed without insert or pop");

endmodule
